/* hdl/asip_pkg.sv */
// ----------------------------------------------------------------------------
// asip_pkg
// Shared types and constants for the ascii to int16 parser.
// ----------------------------------------------------------------------------
package asip_pkg;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_CR    = 8'h0D;

  localparam logic [19:0] POS_LIMIT = 20'd32767;
  localparam logic [19:0] NEG_LIMIT = 20'd32768;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_CUSTOM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_HIGH = 2'd2;

  // count of significant digits taken so far, never above four
  localparam logic [2:0] SIG_FULL = 3'd4;

  typedef struct packed {
    logic        minus_seen;
    logic        plus_seen;
    logic        digit_seen;
    logic [2:0]  sig_count;
    logic [15:0] magnitude;
  } parse_state_t;

  typedef struct packed {
    logic                 use_custom;
    logic [CFG_DAT_W-1:0] strip_low;
    logic [CFG_DAT_W-1:0] strip_high;
  } strip_cfg_t;

  typedef struct packed {
    logic        emit;
    logic        status;
    logic [15:0] value;
    logic        char_taken;
  } parse_result_t;

endpackage

/* hdl/ascii_int16_parser.sv */
// ----------------------------------------------------------------------------
// ascii_int16_parser
// Streaming ascii decimal to signed 16-bit integer parser, one character
// per transfer, with a configurable set of skippable leading characters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_char_in[7:0]
//  out     | output    | out_valid/ out_stall | out_status, out_value, out_char_taken
//  cfg     | input     | cfg_wr_en            | cfg_index[1:0], cfg_wdata[63:0]
//
//  one character per cycle sustained while out_stall does not hold the output;
//  a character waits in the input register and its result, if any, is written
//  to the output register on advance; the parse state and result come from a single
//  step of logic between the two registers, and the parse state feeds back on advance
//  reset clears the parse state, the valid flags and the config registers
//  out_stall holds the output register; the input register then holds and
//  in_stall rises, so at most one character waits while a result is pending
// ----------------------------------------------------------------------------
module ascii_int16_parser import asip_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic signed [15:0]   out_value,
  output logic                 out_char_taken,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  strip_cfg_t    cfg_r;
  logic          in_valid_r;
  logic [7:0]    char_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t result;
  logic          out_valid_r;
  logic          out_status_r;
  logic [15:0]   out_value_r;
  logic          out_char_taken_r;
  logic          advance;
  logic          in_xfer;

  asip_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .char_in   (char_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_USE_CUSTOM: cfg_r.use_custom <= cfg_wdata[0];
        CFG_STRIP_LOW:  cfg_r.strip_low  <= cfg_wdata;
        CFG_STRIP_HIGH: cfg_r.strip_high <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_status_r     <= result.status;
      out_value_r      <= result.value;
      out_char_taken_r <= result.char_taken;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value      = out_value_r;
  assign out_char_taken = out_char_taken_r;

endmodule

/* hdl/asip_step.sv */
// ----------------------------------------------------------------------------
// asip_step
// Next-state and result logic for one character of the parser.
// ----------------------------------------------------------------------------
module asip_step import asip_pkg::*; (
  input  parse_state_t  state,
  input  strip_cfg_t    cfg,
  input  logic [7:0]    char_in,
  output parse_state_t  state_nxt,
  output parse_result_t result
);

  function automatic logic may_strip(input strip_cfg_t sc, input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (c[7] == 1'b0) begin
      r = c[6] ? sc.strip_high[c[5:0]] : sc.strip_low[c[5:0]];
    end
    return r;
  endfunction

  logic        is_digit;
  logic        is_white;
  logic [3:0]  digit;
  logic [19:0] mag_ten;
  logic [19:0] limit;
  logic        emit;
  logic        fail;
  logic        taken;
  logic [15:0] mag_out;
  logic        strip_minus;
  logic        strip_plus;

  assign is_digit    = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_white    = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
  assign digit       = 4'(char_in - CH_ZERO);
  // magnitude * 10 + digit as shifts and adds
  assign mag_ten     = ({4'd0, state.magnitude} << 3) + ({4'd0, state.magnitude} << 1)
                       + {16'd0, digit};
  assign limit       = state.minus_seen ? NEG_LIMIT : POS_LIMIT;
  assign strip_minus = may_strip(cfg, CH_MINUS);
  assign strip_plus  = may_strip(cfg, CH_PLUS);

  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    fail      = 1'b0;
    taken     = 1'b0;
    mag_out   = state.magnitude;
    priority if ((char_in == CH_NUL) && !state.digit_seen) begin
      emit  = 1'b1;
      fail  = 1'b1;
      taken = 1'b1;
    end else if (!is_digit) begin
      priority if (state.digit_seen) begin
        emit = 1'b1;
      end else if (char_in == CH_MINUS) begin
        if (!cfg.use_custom || !strip_minus) begin
          state_nxt.minus_seen = 1'b1;
        end
      end else if (char_in == CH_PLUS) begin
        state_nxt.plus_seen = 1'b1;
      end else if (!cfg.use_custom) begin
        if (!is_white || state.minus_seen) begin
          emit  = 1'b1;
          fail  = 1'b1;
          taken = 1'b1;
        end
      end else if ((state.plus_seen && !strip_plus) ||
                   (state.minus_seen && !strip_minus) ||
                   !may_strip(cfg, char_in)) begin
        emit  = 1'b1;
        fail  = 1'b1;
        taken = 1'b1;
      end else begin
        // skipped character drops any sign seen before it
        state_nxt.plus_seen  = 1'b0;
        state_nxt.minus_seen = 1'b0;
      end
    end else if (state.sig_count >= SIG_FULL) begin
      emit = 1'b1;
      // fifth digit is taken only if it stays in range
      if (mag_ten <= limit) begin
        taken   = 1'b1;
        mag_out = mag_ten[15:0];
      end
    end else begin
      state_nxt.digit_seen = 1'b1;
      if ((state.sig_count != 3'd0) || (digit != 4'd0)) begin
        state_nxt.magnitude = mag_ten[15:0];
        state_nxt.sig_count = state.sig_count + 3'd1;
      end
    end

    if (emit) begin
      state_nxt = '0;
    end

    result.emit       = emit;
    result.status     = fail;
    result.char_taken = taken;
    if (fail) begin
      result.value = 16'd0;
    end else if (state.minus_seen) begin
      result.value = 16'd0 - mag_out;
    end else begin
      result.value = mag_out;
    end
  end

endmodule

/* hdl/asip_checker.sv */
// ----------------------------------------------------------------------------
// asip_checker
// Port-level checks for the ascii to int16 parser, bound to the top level.
// ----------------------------------------------------------------------------
module asip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [15:0] out_value,
  input logic        out_char_taken
);

  // a no-number result always carries zero and consumes the character
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_value == 16'd0) && out_char_taken)
    else $error("no-number result with nonzero value or unconsumed character");

  // nothing is pending right after reset
  a_reset_out: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("output valid or input stalled right after reset");

  // input stalls only while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(out_status) && $stable(out_char_taken))
    else $error("stalled result changed");

endmodule

bind ascii_int16_parser asip_checker u_asip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_value      (out_value),
  .out_char_taken (out_char_taken)
);
